// ===== sv/trq_pkg.sv =====
// package for the timestamp reorder queue: payload types, codes and constants
`default_nettype none
package trq_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_FINAL = 2'd1,
    MODE_ROUND = 2'd2,
    MODE_HALF  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  localparam logic FUNC_QUEUE = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [63:0] stamp;
    logic [63:0] offset_in;
    logic [31:0] event_tag;
    logic [1:0]  flush_mode;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [63:0] stamp_out;
    logic [63:0] offset_out;
    logic [31:0] tag_out;
    logic [31:0] late_count;
    logic        last;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic        flush;
    logic        invalid;
    logic        late;
    logic [63:0] stamp;
    logic [63:0] offset;
    logic [31:0] tag;
    logic [1:0]  mode;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DECIDE,
    B_DRAIN,
    B_POST,
    B_INSERT,
    B_DONE
  } bstate_t;

endpackage
`default_nettype wire

// ===== sv/timestamp_reorder_queue_top.sv =====
// top level of the timestamp reorder queue
`default_nettype none
// Sorted reorder buffer of DEPTH events. A request is taken when start is
// high and busy low; busy stays high until its completion result (last=1)
// has been shown, so the next request is taken in the cycle after it at the
// earliest. Results appear one per cycle on strobe and cannot be held off.
// A request passes the front queue, then decide; a queue request then does the
// shifting insert, an invalid queue request or a flush with nothing to do goes
// straight to the completion, a flush that runs drains events and takes a post
// step, and a queue request that finds the store full half-flushes first and
// then inserts; every request ends with the completion. The drain loop shifts
// the cell row by one entry each cycle, one entry per emitted event.
module timestamp_reorder_queue_top
  import trq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire in_item_t in_item,
  output logic          busy,
  output logic          strobe,
  output out_item_t     result
);

  logic cmd_valid, cmd_take, back_idle;
  cmd_t cmd;

  trq_front u_front (
    .clk, .rst, .start, .in_item, .busy,
    .cmd_valid, .cmd, .cmd_take, .back_idle
  );

  trq_back #(.DEPTH(DEPTH)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take,
    .idle(back_idle), .res_strobe(strobe), .res(result)
  );

endmodule
`default_nettype wire

// ===== sv/trq_front.sv =====
// front end: accepts requests, classifies them and queues them for the back end
`default_nettype none
module trq_front
  import trq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire in_item_t in_item,
  output logic          busy,
  output logic          cmd_valid,
  output cmd_t          cmd,
  input  wire logic     cmd_take,
  input  wire logic     back_idle
);

  // two-entry queue; one item in flight at a time keeps the model order simple
  cmd_t       q [2];
  logic [1:0] cnt;
  logic       rd, wr;
  logic       inflight;
  cmd_t       c;

  always_comb begin
    c.flush   = (in_item.func == FUNC_FLUSH);
    c.invalid = (in_item.func == FUNC_QUEUE) &&
                ((in_item.stamp == '0) || (in_item.stamp == ALL_ONES));
    c.late    = 1'b0;
    c.stamp   = in_item.stamp;
    c.offset  = in_item.offset_in;
    c.tag     = in_item.event_tag;
    c.mode    = in_item.flush_mode;
  end

  assign busy      = inflight || (cnt != 2'd0) || !back_idle;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; rd <= 1'b0; wr <= 1'b0; inflight <= 1'b0;
    end else begin
      inflight <= 1'b0;
      if (start && !busy) begin
        q[wr] <= c;
        wr <= ~wr;
        inflight <= 1'b1;
      end
      if (cmd_take) rd <= ~rd;
      cnt <= cnt + {1'b0, start && !busy} - {1'b0, cmd_take};
    end
  end

endmodule
`default_nettype wire

// ===== sv/trq_back.sv =====
// back end: sorted shifting cell row, drains and completion results
`default_nettype none
module trq_back
  import trq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_take,
  output logic      idle,
  output logic      res_strobe,
  output out_item_t res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [63:0] es [DEPTH];
  logic [63:0] eo [DEPTH];
  logic [31:0] et [DEPTH];
  logic [CW-1:0] occ;
  logic [63:0] recent, limit, lastfl, maxs;
  logic        rvalid;
  logic [31:0] late;
  logic [1:0]  lmode;

  bstate_t st, st_next;
  cmd_t    cur;
  logic [1:0] dmode;     // mode of the flush in progress
  logic       for_ins;   // flush made to free space before an insert
  logic [63:0] old_recent;
  logic [1:0]  status;

  logic full, empty;
  assign full  = (occ == CW'(DEPTH));
  assign empty = (occ == '0);

  // per-cell compare for the sorted insert
  logic [DEPTH-1:0] gt;
  always_comb
    for (int i = 0; i < DEPTH; i++)
      gt[i] = (CW'(i) < occ) && (es[i] > cur.stamp);

  logic [CW-1:0] occ_m1;
  assign occ_m1 = occ - CW'(1);

  logic [63:0] tail;
  assign tail = empty ? 64'd0 : es[occ_m1[IW-1:0]];

  logic head_ok;
  assign head_ok = !empty && (limit != '0) && (es[0] <= limit);

  // request needs a drain pass: a flush with work to do, or a queue into a full row
  logic drain_go;
  assign drain_go = cur.flush ? (!empty && !(cur.mode == MODE_HALF && !rvalid))
                              : (!cur.invalid && full);

  assign idle     = (st == B_IDLE);
  assign cmd_take = (st == B_IDLE) && cmd_valid;

  always_comb begin
    st_next = st;
    res_strobe = 1'b0;
    res = '0;
    res.late_count = late;
    case (st)
      B_IDLE:   if (cmd_valid) st_next = B_DECIDE;
      B_DECIDE: begin
        if (drain_go) st_next = B_DRAIN;
        else if (!cur.flush && !cur.invalid) st_next = B_INSERT;
        else st_next = B_DONE;
      end
      B_DRAIN: begin
        if (head_ok) begin
          res_strobe = 1'b1;
          res.kind = KIND_EVENT;
          res.stamp_out = es[0];
          res.offset_out = eo[0];
          res.tag_out = et[0];
        end else st_next = B_POST;
      end
      B_POST:   st_next = for_ins ? B_INSERT : B_DONE;
      B_INSERT: st_next = B_DONE;
      B_DONE: begin
        res_strobe = 1'b1;
        res.kind = KIND_DONE;
        res.status = status;
        res.last = 1'b1;
        st_next = B_IDLE;
      end
      default: st_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= B_IDLE;
    else st <= st_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0; recent <= '0; rvalid <= 1'b0; limit <= '0;
      lastfl <= '0; maxs <= '0; late <= '0; lmode <= MODE_NONE;
    end else begin
      case (st)
        B_IDLE: if (cmd_valid) begin
          cur <= cmd;
          status <= cmd.invalid ? ST_INVALID : ST_OK;
        end
        B_DECIDE: begin
          for_ins <= !cur.flush;
          dmode <= cur.flush ? cur.mode : MODE_HALF;
          if (!cur.flush && !cur.invalid && cur.stamp < lastfl && late != '1)
            late <= late + 32'd1;
          old_recent <= rvalid ? recent : 64'd0;
          if (drain_go) begin
            if (cur.flush && cur.mode == MODE_FINAL) limit <= ALL_ONES;
            else if (!cur.flush || cur.mode == MODE_HALF)
              limit <= es[0] + ((recent - es[0]) >> 1);
          end
        end
        B_DRAIN: if (head_ok) begin
          lastfl <= es[0];
          for (int i = 0; i < DEPTH - 1; i++) begin
            es[i] <= es[i+1]; eo[i] <= eo[i+1]; et[i] <= et[i+1];
          end
          occ <= occ - CW'(1);
        end
        B_POST: begin
          if (empty) rvalid <= 1'b0;
          else if (old_recent <= limit) begin
            recent <= tail; rvalid <= 1'b1;
          end
          if (dmode == MODE_ROUND) limit <= maxs;
          lmode <= dmode;
        end
        B_INSERT: begin
          if (full) status <= ST_NOSPACE;
          else begin
            if (empty || cur.stamp >= tail) maxs <= cur.stamp;
            // cells above the new stamp move up by one
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (gt[i]) begin
                es[i+1] <= es[i]; eo[i+1] <= eo[i]; et[i+1] <= et[i];
              end
            end
            // place new entry at the first cell whose stamp is greater, or after the last entry if none is
            for (int i = 0; i < DEPTH; i++) begin
              if ((CW'(i) <= occ) && !(i > 0 && gt[(i+DEPTH-1) % DEPTH]) &&
                  (gt[i] || CW'(i) == occ)) begin
                es[i] <= cur.stamp; eo[i] <= cur.offset; et[i] <= cur.tag;
              end
            end
            occ <= occ + CW'(1);
            recent <= cur.stamp;
            rvalid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_occ: assert property (@(posedge clk) disable iff (rst) occ <= CW'(DEPTH))
    else $error("occupancy over depth");
  a_drain_order: assert property (@(posedge clk) disable iff (rst)
      (st == B_DRAIN && head_ok) |-> (es[0] >= lastfl || $past(st) != B_DRAIN))
    else $error("drain out of order");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
      (st == B_DONE) |=> (st == B_IDLE))
    else $error("completion not followed by idle");
`endif

endmodule
`default_nettype wire
